>>> rtl/core/cfrv_pkg.sv
// Shared types, constants and arithmetic helpers for the circular field rotation vector block.
package cfrv_pkg;

	// Width of one input coordinate; only directions matter, so the fraction width plays no part.
	localparam int COORD_WIDTH    = 32;
	// Fraction bits of the result unit vectors.
	localparam int UNIT_FRAC_BITS = 14;
	// Fraction bits of internal unit vectors.
	localparam int UF             = 30;
	localparam int OUT_W          = 16;

	// Widths of the intermediate vectors.
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROJ_W  = 35;
	localparam int SUM_W   = 33;
	localparam int CROSS_W = 63;

	// Pipeline depths.
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 32;
	localparam int BLK_LAT    = 3;
	localparam int UNZ_LAT    = BLK_LAT + 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
	localparam int PRJ_LAT    = BLK_LAT + 4;
	localparam int TOP_LAT    = 5 * UNZ_LAT + PRJ_LAT + 7;

	// Block-scaled component: magnitude below 2^30 and a sign.
	typedef logic signed [UF:0] bw_t;
	// Internal unit component with UF fraction bits, magnitude at most 1.0.
	typedef logic signed [UF+1:0] unit_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] agent_x;
		logic signed [COORD_WIDTH-1:0] agent_y;
		logic signed [COORD_WIDTH-1:0] agent_z;
		logic signed [COORD_WIDTH-1:0] obstacle_x;
		logic signed [COORD_WIDTH-1:0] obstacle_y;
		logic signed [COORD_WIDTH-1:0] obstacle_z;
		logic signed [COORD_WIDTH-1:0] neighbour_x;
		logic signed [COORD_WIDTH-1:0] neighbour_y;
		logic signed [COORD_WIDTH-1:0] neighbour_z;
		logic signed [COORD_WIDTH-1:0] goal_x;
		logic signed [COORD_WIDTH-1:0] goal_y;
		logic signed [COORD_WIDTH-1:0] goal_z;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] rot_x;
		logic signed [OUT_W-1:0] rot_y;
		logic signed [OUT_W-1:0] rot_z;
		logic signed [OUT_W-1:0] cur_x;
		logic signed [OUT_W-1:0] cur_y;
		logic signed [OUT_W-1:0] cur_z;
		logic                    used_fallback;
	} result_t;

	// Shift right by s, rounding the magnitude half up and keeping the sign.
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
			input int unsigned s);
		logic [63:0] m;
		m = x[63] ? 64'(-x) : 64'(x);
		m = (m + (64'd1 << (s - 1))) >> s;
		return x[63] ? -$signed(m) : $signed(m);
	endfunction

	// Rounds an internal unit component to the output format and saturates it to +-1.0.
	function automatic logic [OUT_W-1:0] to_out(input unit_t x);
		logic signed [63:0] y;
		logic signed [63:0] lim;
		lim = 64'sd1 <<< UNIT_FRAC_BITS;
		y   = rnd_shr(64'(x), UF - UNIT_FRAC_BITS);
		if (y > lim) begin
			y = lim;
		end else if (y < -lim) begin
			y = -lim;
		end
		return y[OUT_W-1:0];
	endfunction

endpackage

>>> rtl/core/cfrv_delay.sv
// Fixed-length shift line that keeps side data in step with the pipeline.
module cfrv_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [D];

	always_ff @(posedge clk) begin
		pipe_q[0] <= d;
		for (int i = 1; i < D; i++) begin
			pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[D-1];

endmodule

>>> rtl/core/cfrv_block.sv
// Three-stage block scaler: brings the largest magnitude of a vector into [2^29, 2^30).
module cfrv_block import cfrv_pkg::*; #(
	parameter int W = DIFF_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  logic signed [W-1:0] v [3],
	output logic                vld_o,
	output bw_t                 w [3]
);

	localparam int MW = (W > UF) ? W : UF;
	localparam int LW = $clog2(MW + 1);

	logic [MW-1:0] mag_s1 [3];
	logic [2:0]    neg_s1;
	logic          vld_s1;
	logic [MW-1:0] mag_s2 [3];
	logic [2:0]    neg_s2;
	logic [LW-1:0] len_s2;
	logic          vld_s2;
	logic          vld_s3;
	logic [MW-1:0] big;
	logic [LW-1:0] len;

	always_comb begin
		big = mag_s1[0];
		if (mag_s1[1] > big) begin
			big = mag_s1[1];
		end
		if (mag_s1[2] > big) begin
			big = mag_s1[2];
		end
		len = '0;
		for (int b = 0; b < MW; b++) begin
			if (big[b]) begin
				len = LW'(b + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= MW'(v[i][W-1] ? W'(-v[i]) : W'(v[i]));
			neg_s1[i] <= v[i][W-1];
		end
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		len_s2 <= len;
		for (int i = 0; i < 3; i++) begin
			logic [MW-1:0] sh;
			if (len_s2 > LW'(UF)) begin
				sh = mag_s2[i] >> (len_s2 - LW'(UF));
			end else begin
				sh = mag_s2[i] << (LW'(UF) - len_s2);
			end
			w[i] <= neg_s2[i] ? -bw_t'({1'b0, sh[UF-1:0]}) : bw_t'({1'b0, sh[UF-1:0]});
		end
	end

	assign vld_o = vld_s3;

endmodule

>>> rtl/core/cfrv_unitize.sv
// Pipelined vector normalizer: block scaling, sum of squares, square root and three dividers.
module cfrv_unitize import cfrv_pkg::*; #(
	parameter int W = DIFF_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  logic signed [W-1:0] v [3],
	output logic                vld_o,
	output unit_t               u [3]
);

	localparam int NS = SQRT_STEPS + 1;
	localparam int ND = DIV_STEPS + 1;

	logic          blk_vld;
	bw_t           w [3];

	logic [UF-1:0] mg_sa [3];
	logic [59:0]   sq_sa [3];
	logic [2:0]    neg_sa;
	logic          nz_sa;
	logic          vld_sa;

	// Square root pipeline: radicand remainder, partial root and carried data per stage.
	logic [61:0]   rad_s  [NS];
	logic [62:0]   root_s [NS];
	logic [UF-1:0] mgr_s  [NS][3];
	logic [2:0]    negr_s [NS];
	logic          nzr_s  [NS];
	logic          vldr_s [NS];

	// Divider pipeline, one lane per component.
	logic [31:0]   rem_s  [ND][3];
	logic [31:0]   lo_s   [ND][3];
	logic [31:0]   quo_s  [ND][3];
	logic [30:0]   dvs_s  [ND];
	logic [2:0]    negd_s [ND];
	logic          nzd_s  [ND];
	logic          vldd_s [ND];

	logic          vld_sf;

	cfrv_block #(.W(W)) u_block (
		.clk   (clk),
		.arst_n(arst_n),
		.vld   (vld),
		.v     (v),
		.vld_o (blk_vld),
		.w     (w)
	);

	// Magnitudes and squares.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			logic [UF-1:0] m;
			m          = w[i][UF] ? UF'(-w[i]) : UF'(w[i]);
			mg_sa[i]  <= m;
			sq_sa[i]  <= m * m;
			neg_sa[i] <= w[i][UF];
		end
		nz_sa <= (w[0] != '0) || (w[1] != '0) || (w[2] != '0);
	end

	// Sum of squares enters the root pipeline.
	always_ff @(posedge clk) begin
		rad_s[0]  <= 62'(sq_sa[0]) + 62'(sq_sa[1]) + 62'(sq_sa[2]);
		root_s[0] <= '0;
		mgr_s[0]  <= mg_sa;
		negr_s[0] <= neg_sa;
		nzr_s[0]  <= nz_sa;
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [62:0] trial;
		assign trial = root_s[k] + BIT;
		always_ff @(posedge clk) begin
			if ({1'b0, rad_s[k]} >= trial) begin
				rad_s[k+1]  <= rad_s[k] - trial[61:0];
				root_s[k+1] <= (root_s[k] >> 1) + BIT;
			end else begin
				rad_s[k+1]  <= rad_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
			mgr_s[k+1]  <= mgr_s[k];
			negr_s[k+1] <= negr_s[k];
			nzr_s[k+1]  <= nzr_s[k];
		end
	end

	// Rounded numerator and the top part of it that is known to lie below the divisor.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			logic [60:0] num;
			num          = (61'(mgr_s[SQRT_STEPS][i]) << UF)
				+ 61'(root_s[SQRT_STEPS][30:1]);
			rem_s[0][i] <= 32'(num[60:32]);
			lo_s[0][i]  <= num[31:0];
			quo_s[0][i] <= '0;
		end
		dvs_s[0]  <= root_s[SQRT_STEPS][30:0];
		negd_s[0] <= negr_s[SQRT_STEPS];
		nzd_s[0]  <= nzr_s[SQRT_STEPS];
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				logic [32:0] trial;
				trial = {rem_s[j][i], lo_s[j][i][31]};
				if (trial >= 33'(dvs_s[j])) begin
					rem_s[j+1][i] <= 32'(trial - 33'(dvs_s[j]));
					quo_s[j+1][i] <= {quo_s[j][i][30:0], 1'b1};
				end else begin
					rem_s[j+1][i] <= trial[31:0];
					quo_s[j+1][i] <= {quo_s[j][i][30:0], 1'b0};
				end
				lo_s[j+1][i] <= {lo_s[j][i][30:0], 1'b0};
			end
			dvs_s[j+1]  <= dvs_s[j];
			negd_s[j+1] <= negd_s[j];
			nzd_s[j+1]  <= nzd_s[j];
		end
	end

	// Cap at 1.0, restore the sign; a zero vector stays zero.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			logic [31:0] q;
			q = quo_s[DIV_STEPS][i];
			if (q > (32'd1 << UF)) begin
				q = 32'd1 << UF;
			end
			if (!nzd_s[DIV_STEPS]) begin
				u[i] <= '0;
			end else if (negd_s[DIV_STEPS][i]) begin
				u[i] <= -unit_t'(q);
			end else begin
				u[i] <= unit_t'(q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			vld_sf <= 1'b0;
			for (int k = 0; k < NS; k++) begin
				vldr_s[k] <= 1'b0;
			end
			for (int j = 0; j < ND; j++) begin
				vldd_s[j] <= 1'b0;
			end
		end else begin
			vld_sa    <= blk_vld;
			vldr_s[0] <= vld_sa;
			for (int k = 1; k < NS; k++) begin
				vldr_s[k] <= vldr_s[k-1];
			end
			vldd_s[0] <= vldr_s[SQRT_STEPS];
			for (int j = 1; j < ND; j++) begin
				vldd_s[j] <= vldd_s[j-1];
			end
			vld_sf <= vldd_s[DIV_STEPS];
		end
	end

	assign vld_o = vld_sf;

endmodule

>>> rtl/core/cfrv_project.sv
// Pipelined projection of a block-scaled vector onto the plane normal to a unit vector.
module cfrv_project import cfrv_pkg::*; #(
	parameter int W = DIFF_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld,
	input  logic signed [W-1:0]      v [3],
	input  unit_t                    u [3],
	output logic                     vld_o,
	output logic signed [PROJ_W-1:0] p [3]
);

	localparam int UW = $bits(unit_t);

	logic             blk_vld;
	bw_t              w [3];
	logic [3*UW-1:0]  u_pk;
	logic [3*UW-1:0]  ud_pk;
	unit_t            ud [3];

	logic signed [62:0] pr_s1 [3];
	bw_t                w_s1 [3];
	unit_t              u_s1 [3];
	logic signed [33:0] t_s2;
	bw_t                w_s2 [3];
	unit_t              u_s2 [3];
	logic signed [65:0] pu_s3 [3];
	bw_t                w_s3 [3];
	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;
	logic               vld_s4;

	cfrv_block #(.W(W)) u_block (
		.clk   (clk),
		.arst_n(arst_n),
		.vld   (vld),
		.v     (v),
		.vld_o (blk_vld),
		.w     (w)
	);

	assign u_pk = {u[0], u[1], u[2]};

	cfrv_delay #(.W(3 * UW), .D(BLK_LAT)) u_udly (
		.clk(clk),
		.d  (u_pk),
		.q  (ud_pk)
	);

	assign ud[0] = ud_pk[3*UW-1:2*UW];
	assign ud[1] = ud_pk[2*UW-1:UW];
	assign ud[2] = ud_pk[UW-1:0];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pr_s1[i] <= w[i] * ud[i];
		end
		w_s1 <= w;
		u_s1 <= ud;
		t_s2 <= 34'(rnd_shr(64'(pr_s1[0]) + 64'(pr_s1[1]) + 64'(pr_s1[2]), UF));
		w_s2 <= w_s1;
		u_s2 <= u_s1;
		for (int i = 0; i < 3; i++) begin
			pu_s3[i] <= u_s2[i] * t_s2;
		end
		w_s3 <= w_s2;
		for (int i = 0; i < 3; i++) begin
			p[i] <= PROJ_W'(w_s3[i]) - PROJ_W'(rnd_shr(64'(pu_s3[i]), UF));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= blk_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign vld_o = vld_s4;

endmodule

>>> rtl/core/circular_field_rotation_vector_top.sv
// Top level of the circular field rotation vector engine: dataflow between the arithmetic units.
// The path from an accepted transaction to its result strobe (done) runs through five normalizers in series.
// Throughput: one transaction per cycle; busy stays low, and every pipeline stage moves each cycle.
// Each normalizer consists of block scaling, a square root pipeline and a divider pipeline.
// Reset: arst_n low clears all valid bits at once; data registers are not reset.
// The receiver cannot stall, so a result is shown on result for exactly the cycle done is high.
module circular_field_rotation_vector_top import cfrv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int UW   = $bits(unit_t);
	// Alignment of the side data with the normalizer outputs.
	localparam int D_C  = PRJ_LAT + UNZ_LAT + 1 + UNZ_LAT;
	localparam int D_R  = 2 + UNZ_LAT;
	localparam int D_FB = 3 * UNZ_LAT + 4;

	logic acc;

	// Stage 1: the three difference vectors of the transaction.
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] ao_s1 [3];
	logic signed [DIFF_W-1:0] d_s1  [3];
	logic signed [DIFF_W-1:0] g_s1  [3];

	logic                     u_vld;
	unit_t                    u [3];
	logic [3*DIFF_W-1:0]      d_pk, dd_pk, g_pk, gd_pk;
	logic signed [DIFF_W-1:0] dd [3];
	logic signed [DIFF_W-1:0] gd [3];

	logic                     po_vld, pg_vld;
	logic signed [PROJ_W-1:0] po [3];
	logic signed [PROJ_W-1:0] pg [3];
	logic signed [PROJ_W-1:0] pneg [3];

	logic                     uo_vld, ug_vld;
	unit_t                    uo [3];
	unit_t                    ug [3];

	// Stage 2: sum of the two currents with the fallback applied.
	logic                     vld_s2;
	logic signed [SUM_W-1:0]  s_s2 [3];
	logic                     fb_s2;

	logic                     c_vld;
	unit_t                    c [3];
	logic [3*UW-1:0]          u_pk, uc_pk, ur_pk;
	unit_t                    uc [3];
	unit_t                    ur [3];

	// Stages 3 and 4: first cross product, c x u.
	logic                     vld_s3, vld_s4;
	logic signed [63:0]       pr_s3 [6];
	logic signed [CROSS_W-1:0] t_s4 [3];

	logic                     rot_vld;
	unit_t                    rot [3];
	logic [3*UW-1:0]          rot_pk, rotd_pk;

	// Stages 5 and 6: second cross product, u x rot.
	logic                     vld_s5, vld_s6;
	logic signed [63:0]       pr_s5 [6];
	logic signed [CROSS_W-1:0] t_s6 [3];

	logic                     cur_vld;
	unit_t                    cur [3];
	logic                     fbd;

	logic                     done_q;
	result_t                  result_q;

	// The pipeline never holds off a transaction.
	assign busy = 1'b0;
	assign acc  = start && !busy;

	always_ff @(posedge clk) begin
		ao_s1[0] <= DIFF_W'(item.obstacle_x) - DIFF_W'(item.agent_x);
		ao_s1[1] <= DIFF_W'(item.obstacle_y) - DIFF_W'(item.agent_y);
		ao_s1[2] <= DIFF_W'(item.obstacle_z) - DIFF_W'(item.agent_z);
		d_s1[0]  <= DIFF_W'(item.neighbour_x) - DIFF_W'(item.obstacle_x);
		d_s1[1]  <= DIFF_W'(item.neighbour_y) - DIFF_W'(item.obstacle_y);
		d_s1[2]  <= DIFF_W'(item.neighbour_z) - DIFF_W'(item.obstacle_z);
		g_s1[0]  <= DIFF_W'(item.agent_x) - DIFF_W'(item.goal_x);
		g_s1[1]  <= DIFF_W'(item.agent_y) - DIFF_W'(item.goal_y);
		g_s1[2]  <= DIFF_W'(item.agent_z) - DIFF_W'(item.goal_z);
	end

	// Unit vector from the agent to the obstacle.
	cfrv_unitize #(.W(DIFF_W)) u_unz_ao (
		.clk(clk), .arst_n(arst_n), .vld(vld_s1), .v(ao_s1), .vld_o(u_vld), .u(u)
	);

	// The neighbour and goal vectors wait for u.
	assign d_pk = {d_s1[0], d_s1[1], d_s1[2]};
	assign g_pk = {g_s1[0], g_s1[1], g_s1[2]};

	cfrv_delay #(.W(3 * DIFF_W), .D(UNZ_LAT)) u_ddly (.clk(clk), .d(d_pk), .q(dd_pk));
	cfrv_delay #(.W(3 * DIFF_W), .D(UNZ_LAT)) u_gdly (.clk(clk), .d(g_pk), .q(gd_pk));

	assign dd[0] = dd_pk[3*DIFF_W-1:2*DIFF_W];
	assign dd[1] = dd_pk[2*DIFF_W-1:DIFF_W];
	assign dd[2] = dd_pk[DIFF_W-1:0];
	assign gd[0] = gd_pk[3*DIFF_W-1:2*DIFF_W];
	assign gd[1] = gd_pk[2*DIFF_W-1:DIFF_W];
	assign gd[2] = gd_pk[DIFF_W-1:0];

	// Both projections run side by side.
	cfrv_project #(.W(DIFF_W)) u_prj_obs (
		.clk(clk), .arst_n(arst_n), .vld(u_vld), .v(dd), .u(u), .vld_o(po_vld), .p(po)
	);

	cfrv_project #(.W(DIFF_W)) u_prj_goal (
		.clk(clk), .arst_n(arst_n), .vld(u_vld), .v(gd), .u(u), .vld_o(pg_vld), .p(pg)
	);

	// The obstacle current points against the projected neighbour offset.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pneg[i] = -po[i];
		end
	end

	cfrv_unitize #(.W(PROJ_W)) u_unz_obs (
		.clk(clk), .arst_n(arst_n), .vld(po_vld), .v(pneg), .vld_o(uo_vld), .u(uo)
	);

	cfrv_unitize #(.W(PROJ_W)) u_unz_goal (
		.clk(clk), .arst_n(arst_n), .vld(pg_vld), .v(pg), .vld_o(ug_vld), .u(ug)
	);

	// When the two currents cancel exactly, the direction falls back to +z.
	always_ff @(posedge clk) begin
		logic signed [SUM_W-1:0] s [3];
		for (int i = 0; i < 3; i++) begin
			s[i] = SUM_W'(uo[i]) + SUM_W'(ug[i]);
		end
		if (s[0] == '0 && s[1] == '0 && s[2] == '0) begin
			fb_s2   <= 1'b1;
			s_s2[0] <= '0;
			s_s2[1] <= '0;
			s_s2[2] <= SUM_W'(1) <<< UF;
		end else begin
			fb_s2 <= 1'b0;
			s_s2  <= s;
		end
	end

	cfrv_unitize #(.W(SUM_W)) u_unz_sum (
		.clk(clk), .arst_n(arst_n), .vld(vld_s2), .v(s_s2), .vld_o(c_vld), .u(c)
	);

	assign u_pk = {u[0], u[1], u[2]};

	cfrv_delay #(.W(3 * UW), .D(D_C)) u_udly_c (.clk(clk), .d(u_pk), .q(uc_pk));
	cfrv_delay #(.W(3 * UW), .D(D_R)) u_udly_r (.clk(clk), .d(uc_pk), .q(ur_pk));

	assign uc[0] = uc_pk[3*UW-1:2*UW];
	assign uc[1] = uc_pk[2*UW-1:UW];
	assign uc[2] = uc_pk[UW-1:0];
	assign ur[0] = ur_pk[3*UW-1:2*UW];
	assign ur[1] = ur_pk[2*UW-1:UW];
	assign ur[2] = ur_pk[UW-1:0];

	// Rotation axis: products are registered before the differences are taken.
	always_ff @(posedge clk) begin
		pr_s3[0] <= c[1] * uc[2];
		pr_s3[1] <= c[2] * uc[1];
		pr_s3[2] <= c[2] * uc[0];
		pr_s3[3] <= c[0] * uc[2];
		pr_s3[4] <= c[0] * uc[1];
		pr_s3[5] <= c[1] * uc[0];
		t_s4[0]  <= CROSS_W'(pr_s3[0] - pr_s3[1]);
		t_s4[1]  <= CROSS_W'(pr_s3[2] - pr_s3[3]);
		t_s4[2]  <= CROSS_W'(pr_s3[4] - pr_s3[5]);
	end

	cfrv_unitize #(.W(CROSS_W)) u_unz_rot (
		.clk(clk), .arst_n(arst_n), .vld(vld_s4), .v(t_s4), .vld_o(rot_vld), .u(rot)
	);

	// Circular current: u crossed with the rotation axis.
	always_ff @(posedge clk) begin
		pr_s5[0] <= ur[1] * rot[2];
		pr_s5[1] <= ur[2] * rot[1];
		pr_s5[2] <= ur[2] * rot[0];
		pr_s5[3] <= ur[0] * rot[2];
		pr_s5[4] <= ur[0] * rot[1];
		pr_s5[5] <= ur[1] * rot[0];
		t_s6[0]  <= CROSS_W'(pr_s5[0] - pr_s5[1]);
		t_s6[1]  <= CROSS_W'(pr_s5[2] - pr_s5[3]);
		t_s6[2]  <= CROSS_W'(pr_s5[4] - pr_s5[5]);
	end

	cfrv_unitize #(.W(CROSS_W)) u_unz_cur (
		.clk(clk), .arst_n(arst_n), .vld(vld_s6), .v(t_s6), .vld_o(cur_vld), .u(cur)
	);

	// The rotation axis and the fallback flag wait for the circular current.
	assign rot_pk = {rot[0], rot[1], rot[2]};

	cfrv_delay #(.W(3 * UW), .D(D_R)) u_rotdly (.clk(clk), .d(rot_pk), .q(rotd_pk));
	cfrv_delay #(.W(1), .D(D_FB)) u_fbdly (.clk(clk), .d(fb_s2), .q(fbd));

	// Output register: rounding to the result format and saturation.
	always_ff @(posedge clk) begin
		result_q.rot_x         <= to_out(rotd_pk[3*UW-1:2*UW]);
		result_q.rot_y         <= to_out(rotd_pk[2*UW-1:UW]);
		result_q.rot_z         <= to_out(rotd_pk[UW-1:0]);
		result_q.cur_x         <= to_out(cur[0]);
		result_q.cur_y         <= to_out(cur[1]);
		result_q.cur_z         <= to_out(cur[2]);
		result_q.used_fallback <= fbd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= uo_vld && ug_vld;
			vld_s3 <= c_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= rot_vld;
			vld_s6 <= vld_s5;
			done_q <= cur_vld;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/core/cfrv_checker.sv
// Port-level checker for the circular field rotation vector engine, bound to the top level.
module cfrv_port_checks import cfrv_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	localparam logic signed [OUT_W-1:0] LIM = OUT_W'(1 << UNIT_FRAC_BITS);

	// Every result comes a fixed number of cycles after its transaction.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOP_LAT))
		else $error("result without a transaction at the fixed latency");

	// With the +z fallback the rotation axis lies in the xy plane.
	a_fallback_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.used_fallback |-> result.rot_z == '0)
		else $error("fallback result with a z component of the rotation axis");

	// A zero rotation axis leaves no circular current.
	a_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.rot_x == '0 && result.rot_y == '0 && result.rot_z == '0
		|-> result.cur_x == '0 && result.cur_y == '0 && result.cur_z == '0)
		else $error("circular current without a rotation axis");

	// The x components of both vectors and the z component of the circular current stay within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.rot_x <= LIM && result.rot_x >= -LIM
			&& result.cur_x <= LIM && result.cur_x >= -LIM
			&& result.cur_z <= LIM && result.cur_z >= -LIM)
		else $error("unit component out of range");

endmodule

bind circular_field_rotation_vector_top cfrv_port_checks u_cfrv_port_checks (.*);
